### design/ppbs_pkg.sv
`timescale 1ns / 1ps
package ppbs_pkg;

	localparam int FRAME_W   = 13;
	localparam int COORD_W   = 12;
	localparam int RGB_W     = 24;
	localparam int DAC_W     = 6;
	localparam int POS_W     = 14;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;
	localparam logic [FRAME_W-1:0] FRAME_LIMIT = 13'd4096;
	localparam logic [FRAME_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [FRAME_W-1:0] HEIGHT_RESET = 13'd480;

	// register index taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic FUNC_PALETTE = 1'b0;
	localparam logic FUNC_PLOT    = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCALE  = 5'b00010,
		ST_ORIGIN = 5'b00100,
		ST_BASE   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic calc_scale;
		logic calc_origin;
		logic calc_base;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic plot_ok;
		logic last_pix;
	} sts_t;

	// widen a 6-bit DAC value by copying its top two bits below
	function automatic logic [7:0] widen_dac(input logic [7:0] v);
		return {v[DAC_W-1:0], v[DAC_W-1:DAC_W-2]};
	endfunction

endpackage

### design/ppbs_regs.sv
`timescale 1ns / 1ps
module ppbs_regs
	import ppbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	output logic [FRAME_W-1:0]  frame_width,
	output logic [FRAME_W-1:0]  frame_height
);

	logic [FRAME_W-1:0] width_q;
	logic [FRAME_W-1:0] height_q;
	logic [FRAME_W-1:0] wr_val;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	// clamp oversized sizes so every coordinate fits in 12 bits
	assign wr_val = (pwdata[FRAME_W-1:0] > FRAME_LIMIT) ? FRAME_LIMIT : pwdata[FRAME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= wr_val;
				REG_FRAME_HEIGHT: height_q <= wr_val;
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {{(APB_DW-FRAME_W){1'b0}}, width_q};
			REG_FRAME_HEIGHT: prdata = {{(APB_DW-FRAME_W){1'b0}}, height_q};
			default:          prdata = '0;
		endcase
	end

	assign frame_width  = width_q;
	assign frame_height = height_q;

endmodule

### design/ppbs_ctrl.sv
`timescale 1ns / 1ps
module ppbs_ctrl
	import ppbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				// palette writes and clipped plots finish at acceptance
				if (start && sts.plot_ok) state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.calc_scale = 1'b1;
				state_nxt      = ST_ORIGIN;
			end
			ST_ORIGIN: begin
				cmd.calc_origin = 1'b1;
				state_nxt       = ST_BASE;
			end
			ST_BASE: begin
				cmd.calc_base = 1'b1;
				state_nxt     = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.last_pix) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### design/ppbs_dp.sv
`timescale 1ns / 1ps
module ppbs_dp
	import ppbs_pkg::*;
#(
	parameter int GRID_WIDTH      = 320,
	parameter int GRID_HEIGHT     = 200,
	parameter int MAX_SCALE       = 6,
	parameter int PALETTE_ENTRIES = 256
)(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [FRAME_W-1:0] frame_width,
	input  logic [FRAME_W-1:0] frame_height,
	input  logic               func,
	input  logic [15:0]        grid_x,
	input  logic [15:0]        grid_y,
	input  logic [7:0]         color_index,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	output logic               pixel_valid,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [RGB_W-1:0]   pixel_rgb,
	output logic               last_write
);

	localparam int GX_W = $clog2(GRID_WIDTH + 1);
	localparam int GY_W = $clog2(GRID_HEIGHT + 1);
	localparam int SC_W = $clog2(MAX_SCALE + 1);
	localparam int PI_W = $clog2(PALETTE_ENTRIES);

	logic [RGB_W-1:0]           pal_mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] pal_valid_q;
	logic [RGB_W-1:0]           pal_rd_q;
	logic                       pal_hit_q;
	logic                       idx_ok;
	logic [PI_W-1:0]            idx;
	logic                       in_grid;

	logic [GX_W-1:0]  gx_q;
	logic [GY_W-1:0]  gy_q;
	logic [SC_W-1:0]  scale_nxt;
	logic [SC_W-1:0]  scale_q;
	logic [POS_W-1:0] span_x;
	logic [POS_W-1:0] span_y;
	logic [POS_W-1:0] ox_q;
	logic [POS_W-1:0] oy_q;
	logic [POS_W-1:0] gxs_q;
	logic [POS_W-1:0] gys_q;
	logic [POS_W-1:0] fx_q;
	logic [POS_W-1:0] fy_q;
	logic [SC_W-1:0]  dx_q;
	logic [SC_W-1:0]  dy_q;
	logic             dx_end;
	logic             dy_end;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [RGB_W-1:0]   out_rgb_q;
	logic               out_last_q;

	assign idx     = color_index[PI_W-1:0];
	assign idx_ok  = ({1'b0, color_index} < 9'(PALETTE_ENTRIES));
	assign in_grid = !grid_x[15] && (grid_x < 16'(GRID_WIDTH))
	              && !grid_y[15] && (grid_y < 16'(GRID_HEIGHT));
	assign sts.plot_ok = (func == FUNC_PLOT) && in_grid;

	// palette store: write on a palette request, read on every request
	always_ff @(posedge clk) begin
		if (cmd.accept && (func == FUNC_PALETTE) && idx_ok) begin
			pal_mem[idx] <= {widen_dac(red_in), widen_dac(green_in), widen_dac(blue_in)};
		end
		if (cmd.accept) begin
			pal_rd_q <= pal_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
			pal_hit_q   <= 1'b0;
		end else if (cmd.accept) begin
			if ((func == FUNC_PALETTE) && idx_ok) pal_valid_q[idx] <= 1'b1;
			pal_hit_q <= idx_ok && pal_valid_q[idx];
		end
	end

	// largest scale whose grid fits both axes, at least one
	always_comb begin
		scale_nxt = SC_W'(1);
		for (int i = 1; i <= MAX_SCALE; i++) begin
			if ((POS_W'(GRID_WIDTH * i) <= {1'b0, frame_width})
			    && (POS_W'(GRID_HEIGHT * i) <= {1'b0, frame_height})) begin
				scale_nxt = SC_W'(i);
			end
		end
	end

	assign span_x = POS_W'(GRID_WIDTH * scale_q);
	assign span_y = POS_W'(GRID_HEIGHT * scale_q);
	assign dx_end = (dx_q == scale_q - SC_W'(1));
	assign dy_end = (dy_q == scale_q - SC_W'(1));
	assign sts.last_pix = dx_end && dy_end;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gx_q <= grid_x[GX_W-1:0];
			gy_q <= grid_y[GY_W-1:0];
		end
		if (cmd.calc_scale) begin
			scale_q <= scale_nxt;
		end
		if (cmd.calc_origin) begin
			ox_q  <= ({1'b0, frame_width} > span_x)
			       ? (({1'b0, frame_width} - span_x) >> 1) : '0;
			oy_q  <= ({1'b0, frame_height} > span_y)
			       ? (({1'b0, frame_height} - span_y) >> 1) : '0;
			gxs_q <= POS_W'(gx_q * scale_q);
			gys_q <= POS_W'(gy_q * scale_q);
		end
		if (cmd.calc_base) begin
			fx_q <= ox_q + gxs_q;
			fy_q <= oy_q + gys_q;
			dx_q <= '0;
			dy_q <= '0;
		end else if (cmd.emit) begin
			// advance row-major over the scale x scale block
			if (dx_end) begin
				dx_q <= '0;
				dy_q <= dy_q + SC_W'(1);
			end else begin
				dx_q <= dx_q + SC_W'(1);
			end
		end
		if (cmd.emit) begin
			out_x_q    <= COORD_W'(fx_q + POS_W'(dx_q));
			out_y_q    <= COORD_W'(fy_q + POS_W'(dy_q));
			out_rgb_q  <= pal_hit_q ? pal_rd_q : '0;
			out_last_q <= sts.last_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_rgb   = out_rgb_q;
	assign last_write  = out_last_q;

endmodule

### design/palette_pixel_block_scaler_core.sv
`timescale 1ns / 1ps
// Flow: after acceptance a plot passes through the scale, origin and base states, then emits its writes,
// which are registered before they reach the result ports; busy holds until the last write is emitted,
// so a new plot is taken only after the previous one, one write a cycle from the block counter;
// a palette write or a clipped plot finishes at acceptance and gives no result.
// The receiver cannot stall: each write is strobed by pixel_valid for one cycle.
// Reset (arst_n low) clears the palette to black, sets 640x480 and returns to idle.
module palette_pixel_block_scaler_core
	import ppbs_pkg::*;
#(
	parameter int GRID_WIDTH      = 320,
	parameter int GRID_HEIGHT     = 200,
	parameter int MAX_SCALE       = 6,
	parameter int PALETTE_ENTRIES = 256
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [15:0]        grid_x,
	input  logic [15:0]        grid_y,
	input  logic [7:0]         color_index,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	output logic               pixel_valid,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [RGB_W-1:0]   pixel_rgb,
	output logic               last_write
);

	logic [FRAME_W-1:0] frame_width;
	logic [FRAME_W-1:0] frame_height;
	cmd_t               cmd;
	sts_t               sts;

	ppbs_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height)
	);

	ppbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ppbs_dp #(
		.GRID_WIDTH      (GRID_WIDTH),
		.GRID_HEIGHT     (GRID_HEIGHT),
		.MAX_SCALE       (MAX_SCALE),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.func         (func),
		.grid_x       (grid_x),
		.grid_y       (grid_y),
		.color_index  (color_index),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.pixel_valid  (pixel_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_rgb    (pixel_rgb),
		.last_write   (last_write)
	);

endmodule

### verif/ppbs_checker.sv
`timescale 1ns / 1ps
module ppbs_checker
	import ppbs_pkg::*;
#(
	parameter int GRID_WIDTH      = 320,
	parameter int GRID_HEIGHT     = 200,
	parameter int MAX_SCALE       = 6,
	parameter int PALETTE_ENTRIES = 256
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic [15:0]        grid_x,
	input  logic [15:0]        grid_y,
	input  logic [7:0]         color_index,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic               pixel_valid,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [RGB_W-1:0]   pixel_rgb,
	input  logic               last_write,
	output int                 fails,
	output int                 backlog
);

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RGB_W-1:0]   rgb;
		logic               last;
	} pix_write_t;

	pix_write_t         due_writes[$];
	pix_write_t         got_w;
	logic [RGB_W-1:0]   colors [PALETTE_ENTRIES];
	logic [FRAME_W-1:0] frame_w;
	logic [FRAME_W-1:0] frame_h;
	logic [FRAME_W-1:0] reg_val;

	// 6-bit DAC level to 8 bits: repeat the top two bits at the bottom
	function automatic logic [7:0] dac8(input logic [7:0] v);
		return {v[5:0], v[5:4]};
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		fails++;
	endtask

	task automatic queue_block_writes(input logic [15:0] gx_raw, input logic [15:0] gy_raw,
			input logic [7:0] idx);
		int gx;
		int gy;
		int unsigned fw;
		int unsigned fh;
		int unsigned s;
		int unsigned ox;
		int unsigned oy;
		int unsigned fx;
		int unsigned fy;
		logic [RGB_W-1:0] rgb;
		pix_write_t w;
		gx = int'($signed(gx_raw));
		gy = int'($signed(gy_raw));
		// drop plots outside the grid
		if (gx < 0 || gx >= GRID_WIDTH || gy < 0 || gy >= GRID_HEIGHT)
			return;
		fw = 32'(frame_w);
		fh = 32'(frame_h);
		s = fw / GRID_WIDTH;
		if (fh / GRID_HEIGHT < s)
			s = fh / GRID_HEIGHT;
		if (s < 1)
			s = 1;
		if (s > MAX_SCALE)
			s = MAX_SCALE;
		ox = (fw > GRID_WIDTH * s) ? (fw - GRID_WIDTH * s) / 2 : 0;
		oy = (fh > GRID_HEIGHT * s) ? (fh - GRID_HEIGHT * s) / 2 : 0;
		fx = ox + gx * s;
		fy = oy + gy * s;
		rgb = (idx < PALETTE_ENTRIES) ? colors[idx] : '0;
		for (int unsigned dy = 0; dy < s; dy++) begin
			for (int unsigned dx = 0; dx < s; dx++) begin
				w.x = COORD_W'(fx + dx);
				w.y = COORD_W'(fy + dy);
				w.rgb = rgb;
				w.last = (dy == s - 1) && (dx == s - 1);
				due_writes.push_back(w);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++)
				colors[i] = '0;
			frame_w = WIDTH_RESET;
			frame_h = HEIGHT_RESET;
			due_writes.delete();
			fails = 0;
			backlog = 0;
		end else begin
			// retire writes before queueing new ones from this edge
			if (pixel_valid) begin
				if (due_writes.size() == 0) begin
					flag_mismatch($sformatf("unexpected write x=%0d y=%0d rgb=%06h last=%0b",
						pixel_x, pixel_y, pixel_rgb, last_write));
				end else begin
					got_w = due_writes.pop_front();
					if (pixel_x !== got_w.x)
						flag_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, got_w.x));
					if (pixel_y !== got_w.y)
						flag_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, got_w.y));
					if (pixel_rgb !== got_w.rgb)
						flag_mismatch($sformatf("pixel_rgb %06h, want %06h", pixel_rgb,
							got_w.rgb));
					if (last_write !== got_w.last)
						flag_mismatch($sformatf("last_write %0b, want %0b", last_write,
							got_w.last));
				end
			end
			if (psel && penable && pwrite && pready) begin
				reg_val = pwdata[FRAME_W-1:0];
				if (reg_val > FRAME_LIMIT)
					reg_val = FRAME_LIMIT;
				if (paddr[2] == REG_FRAME_WIDTH)
					frame_w = reg_val;
				else
					frame_h = reg_val;
			end
			if (start && !busy) begin
				if (func == FUNC_PALETTE) begin
					if (color_index < PALETTE_ENTRIES)
						colors[color_index] = {dac8(red_in), dac8(green_in), dac8(blue_in)};
				end else begin
					queue_block_writes(grid_x, grid_y, color_index);
				end
			end
			backlog = due_writes.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import ppbs_pkg::*;

	localparam int GRID_W     = 320;
	localparam int GRID_H     = 200;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES     = 10;
	localparam int PHASE_ITEMS = 38;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic               func;
	logic [15:0]        grid_x;
	logic [15:0]        grid_y;
	logic [7:0]         color_index;
	logic [7:0]         red_in;
	logic [7:0]         green_in;
	logic [7:0]         blue_in;
	logic               pixel_valid;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [RGB_W-1:0]   pixel_rgb;
	logic               last_write;
	int                 fails;
	int                 backlog;
	int                 idle_cycles;

	int unsigned width_plan  [PHASES-1] = '{4096, 1, 0, 1920, 8191, 323, 1000, 2000, 1279};
	int unsigned height_plan [PHASES-1] = '{4096, 1, 0, 1200, 5000, 203, 700, 250, 4095};

	palette_pixel_block_scaler_core #(
		.GRID_WIDTH(GRID_W),
		.GRID_HEIGHT(GRID_H)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.func(func), .grid_x(grid_x), .grid_y(grid_y), .color_index(color_index),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.pixel_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_rgb(pixel_rgb), .last_write(last_write)
	);

	ppbs_checker #(
		.GRID_WIDTH(GRID_W),
		.GRID_HEIGHT(GRID_H)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.start(start), .busy(busy),
		.func(func), .grid_x(grid_x), .grid_y(grid_y), .color_index(color_index),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.pixel_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_rgb(pixel_rgb), .last_write(last_write),
		.fails(fails), .backlog(backlog)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || pixel_valid || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap(input bit burst);
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one request: hold start until the block takes it
	task automatic send_item(input logic f, input logic [15:0] gx, input logic [15:0] gy,
			input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input int gap);
		@(negedge clk);
		repeat (gap) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		func = f;
		grid_x = gx;
		grid_y = gy;
		color_index = idx;
		red_in = r;
		green_in = g;
		blue_in = b;
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain_block();
		@(negedge clk);
		start = 1'b0;
		while (backlog != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input int unsigned value);
		logic [APB_DW-1:0] data;
		data = APB_DW'(value[FRAME_W-1:0]);
		// junk above the register width is dropped by the block
		if ($urandom_range(0, 1))
			data = data | ($urandom() & ~32'h1FFF);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_sel, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_random_item(input bit burst);
		int sel;
		int kind;
		logic [15:0] gx;
		logic [15:0] gy;
		logic [7:0] idx;
		sel = $urandom_range(0, 99);
		gx = 16'($urandom());
		gy = 16'($urandom());
		idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom());
		if (sel < 35) begin
			send_item(FUNC_PALETTE, gx, gy, idx, 8'($urandom()), 8'($urandom()),
				8'($urandom()), pick_gap(burst));
		end else begin
			if (sel < 85) begin
				gx = $urandom_range(0, 9) == 0 ? 16'(GRID_W - 1)
					: 16'($urandom_range(0, GRID_W - 1));
				gy = $urandom_range(0, 9) == 0 ? 16'(GRID_H - 1)
					: 16'($urandom_range(0, GRID_H - 1));
			end else begin
				kind = $urandom_range(0, 3);
				case (kind)
					1: begin
						gx = 16'(-$urandom_range(1, 32768));
						gy = 16'($urandom_range(0, GRID_H - 1));
					end
					2: begin
						gx = 16'($urandom_range(0, GRID_W - 1));
						gy = 16'($urandom_range(GRID_H, 32767));
					end
					3: gx = 16'($urandom_range(GRID_W, 32767));
					default: ;
				endcase
			end
			send_item(FUNC_PLOT, gx, gy, idx, 8'($urandom()), 8'($urandom()),
				8'($urandom()), pick_gap(burst));
		end
	endtask

	initial begin
		bit burst;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		func = FUNC_PALETTE;
		grid_x = '0;
		grid_y = '0;
		color_index = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset frame size
		send_item(FUNC_PALETTE, 16'hFFFF, 16'hFFFF, 8'd0, 8'hFF, 8'hC0, 8'h3F, 0);
		send_item(FUNC_PALETTE, 16'h0000, 16'h0000, 8'd255, 8'h3F, 8'h15, 8'h2A, 0);
		send_item(FUNC_PALETTE, 16'h1234, 16'h8765, 8'd128, 8'h80, 8'h7F, 8'h01, 1);
		send_item(FUNC_PLOT, 16'd0, 16'd0, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'(GRID_W - 1), 16'(GRID_H - 1), 8'd255, 8'hFF, 8'hFF, 8'hFF, 0);
		send_item(FUNC_PLOT, 16'd5, 16'd7, 8'd9, 8'h00, 8'h00, 8'h00, 2);
		send_item(FUNC_PLOT, 16'hFFFF, 16'd0, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'(GRID_W), 16'd0, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'd0, 16'(GRID_H), 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'd0, 16'hFFFF, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'h8000, 16'h7FFF, 8'd255, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'h7FFF, 16'h8000, 8'd255, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PALETTE, 16'd0, 16'd0, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'd160, 16'd100, 8'd0, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PALETTE, 16'd0, 16'd0, 8'd17, 8'hC0, 8'hC0, 8'hC0, 0);
		send_item(FUNC_PLOT, 16'd17, 16'd3, 8'd17, 8'h00, 8'h00, 8'h00, 0);
		send_item(FUNC_PLOT, 16'(GRID_W - 1), 16'd0, 8'd128, 8'hAA, 8'h55, 8'hAA, 5);
		send_item(FUNC_PLOT, 16'd0, 16'(GRID_H - 1), 8'd255, 8'h00, 8'h00, 8'h00, 0);

		for (int p = 0; p < PHASES; p++) begin
			drain_block();
			if (p < PHASES - 1) begin
				apb_write(REG_FRAME_WIDTH, width_plan[p]);
				apb_write(REG_FRAME_HEIGHT, height_plan[p]);
			end else begin
				apb_write(REG_FRAME_HEIGHT, $urandom_range(0, 8191));
				apb_write(REG_FRAME_WIDTH, $urandom_range(0, 8191));
			end
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// switch between steady streaming and gapped requests now and then
				if ($urandom_range(0, 15) == 0)
					burst = !burst;
				send_random_item(burst);
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (backlog != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fails == 0 && backlog == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
